@@ rtl/jsu_pkg.sv @@
package jsu_pkg;

    localparam int unsigned JSU_CHAR_W     = 16;
    localparam int unsigned JSU_MAX_OUT    = 3;
    localparam int unsigned JSU_FIFO_DEPTH = 2;

    localparam logic [JSU_CHAR_W-1:0] CH_BACKSLASH = 16'h005C;
    localparam logic [JSU_CHAR_W-1:0] CH_U         = 16'h0075;
    localparam logic [JSU_CHAR_W-1:0] CH_B         = 16'h0062;
    localparam logic [JSU_CHAR_W-1:0] CH_F         = 16'h0066;
    localparam logic [JSU_CHAR_W-1:0] CH_N         = 16'h006E;
    localparam logic [JSU_CHAR_W-1:0] CH_R         = 16'h0072;
    localparam logic [JSU_CHAR_W-1:0] CH_T         = 16'h0074;
    localparam logic [JSU_CHAR_W-1:0] CTL_BS       = 16'h0008;
    localparam logic [JSU_CHAR_W-1:0] CTL_FF       = 16'h000C;
    localparam logic [JSU_CHAR_W-1:0] CTL_LF       = 16'h000A;
    localparam logic [JSU_CHAR_W-1:0] CTL_CR       = 16'h000D;
    localparam logic [JSU_CHAR_W-1:0] CTL_TAB      = 16'h0009;

    typedef enum logic [1:0] {
        PH_PLAIN = 2'd0,
        PH_ESC   = 2'd1,
        PH_HEX   = 2'd2
    } jsu_phase_t;

    // Results caused by one input beat; cnt is 1 to 3 for a queued bundle.
    typedef struct packed {
        logic [1:0]                              cnt;
        logic [JSU_MAX_OUT-1:0][JSU_CHAR_W-1:0]  chars;
    } jsu_bundle_t;

    function automatic logic [3:0] hex_digit(input logic [JSU_CHAR_W-1:0] c);
        logic [3:0] v;
        v = 4'd0;
        if (c >= 16'h0030 && c <= 16'h0039) begin
            v = 4'(c - 16'h0030);
        end else if (c >= 16'h0041 && c <= 16'h0046) begin
            v = 4'(c - 16'h0041 + 16'd10);
        end else if (c >= 16'h0061 && c <= 16'h0066) begin
            v = 4'(c - 16'h0061 + 16'd10);
        end
        return v;
    endfunction

    function automatic logic [JSU_CHAR_W-1:0] esc_map(input logic [JSU_CHAR_W-1:0] c);
        logic [JSU_CHAR_W-1:0] v;
        case (c)
            CH_B:    v = CTL_BS;
            CH_F:    v = CTL_FF;
            CH_N:    v = CTL_LF;
            CH_R:    v = CTL_CR;
            CH_T:    v = CTL_TAB;
            default: v = c;
        endcase
        return v;
    endfunction

endpackage

@@ rtl/jsu_front.sv @@
module jsu_front import jsu_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    input  logic                  in_ready,
    input  logic [JSU_CHAR_W-1:0] in_char,
    input  logic                  in_last,
    output logic                  push,
    output jsu_bundle_t           push_data
);

    jsu_phase_t            phase_reg, phase_next;
    logic [1:0]            count_reg, count_next;
    logic [JSU_CHAR_W-1:0] held_reg  [3];
    logic [JSU_CHAR_W-1:0] held_next [3];
    logic                  accept;

    assign accept = in_valid && in_ready;

    always_comb begin
        phase_next = phase_reg;
        case (phase_reg)
            PH_PLAIN: begin
                if (in_char == CH_BACKSLASH && !in_last) begin
                    phase_next = PH_ESC;
                end
            end
            PH_ESC: begin
                if (in_char == CH_U && !in_last) begin
                    phase_next = PH_HEX;
                end else begin
                    phase_next = PH_PLAIN;
                end
            end
            PH_HEX: begin
                if (count_reg == 2'd3 || in_last) begin
                    phase_next = PH_PLAIN;
                end
            end
            default: phase_next = PH_PLAIN;
        endcase
    end

    always_comb begin
        logic [1:0]            n;
        logic [JSU_CHAR_W-1:0] ch  [3];
        logic [JSU_CHAR_W-1:0] seq [3];
        jsu_phase_t            rp;
        logic                  isl;
        n          = 2'd0;
        ch         = '{default: '0};
        seq        = '{default: '0};
        rp         = PH_PLAIN;
        isl        = 1'b0;
        count_next = count_reg;
        held_next  = held_reg;
        case (phase_reg)
            PH_PLAIN: begin
                if (!(in_char == CH_BACKSLASH && !in_last)) begin
                    ch[0] = in_char;
                    n     = 2'd1;
                end
            end
            PH_ESC: begin
                if (in_char == CH_U) begin
                    count_next = 2'd0;
                end else begin
                    ch[0] = esc_map(in_char);
                    n     = 2'd1;
                end
            end
            PH_HEX: begin
                if (count_reg == 2'd3) begin
                    ch[0] = {hex_digit(held_reg[0]), hex_digit(held_reg[1]),
                             hex_digit(held_reg[2]), hex_digit(in_char)};
                    n          = 2'd1;
                    count_next = 2'd0;
                end else if (in_last) begin
                    // The string ended inside the hex digits: the collected
                    // characters are decoded again from the plain phase.
                    count_next = 2'd0;
                    for (int i = 0; i < 3; i++) begin
                        if (2'(i) < count_reg) begin
                            seq[i] = held_reg[i];
                        end else if (2'(i) == count_reg) begin
                            seq[i] = in_char;
                        end
                    end
                    for (int i = 0; i < 3; i++) begin
                        if (2'(i) <= count_reg) begin
                            isl = (2'(i) == count_reg);
                            case (rp)
                                PH_PLAIN: begin
                                    if (seq[i] == CH_BACKSLASH && !isl) begin
                                        rp = PH_ESC;
                                    end else begin
                                        ch[n] = seq[i];
                                        n     = n + 2'd1;
                                    end
                                end
                                PH_ESC: begin
                                    rp = PH_PLAIN;
                                    if (seq[i] == CH_U) begin
                                        if (!isl) begin
                                            rp = PH_HEX;
                                        end
                                    end else begin
                                        ch[n] = esc_map(seq[i]);
                                        n     = n + 2'd1;
                                    end
                                end
                                default: begin
                                    ch[n] = seq[i];
                                    n     = n + 2'd1;
                                    rp    = PH_PLAIN;
                                end
                            endcase
                        end
                    end
                end else begin
                    held_next[count_reg] = in_char;
                    count_next           = count_reg + 2'd1;
                end
            end
            default: count_next = 2'd0;
        endcase
        push_data.cnt = n;
        for (int i = 0; i < 3; i++) begin
            push_data.chars[i] = ch[i];
        end
        push = accept && (n != 2'd0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_PLAIN;
            count_reg <= 2'd0;
        end else if (accept) begin
            phase_reg <= phase_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            held_reg <= held_next;
        end
    end

endmodule

@@ rtl/jsu_fifo.sv @@
module jsu_fifo import jsu_pkg::*; #(
    parameter int unsigned DEPTH = JSU_FIFO_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        push,
    input  jsu_bundle_t push_data,
    output logic        not_full,
    input  logic        pop,
    output logic        head_valid,
    output jsu_bundle_t head_data
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    jsu_bundle_t      mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic             do_push, do_pop;

    assign not_full   = (fill_reg != CNT_W'(DEPTH));
    assign head_valid = (fill_reg != '0);
    assign head_data  = mem_reg[rd_ptr_reg];
    assign do_push    = push && not_full;
    assign do_pop     = pop && head_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            fill_next = fill_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ rtl/jsu_back.sv @@
module jsu_back import jsu_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  head_valid,
    input  jsu_bundle_t           head_data,
    output logic                  pop,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [JSU_CHAR_W-1:0] out_char,
    output logic                  out_last
);

    logic [1:0] idx_reg, idx_next;
    logic       beat;

    assign out_valid = head_valid;
    assign out_char  = head_data.chars[idx_reg];
    assign out_last  = (idx_reg == head_data.cnt - 2'd1);
    assign beat      = out_valid && out_ready;
    assign pop       = beat && out_last;

    always_comb begin
        idx_next = idx_reg;
        if (pop) begin
            idx_next = 2'd0;
        end else if (beat) begin
            idx_next = idx_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg <= 2'd0;
        end else begin
            idx_reg <= idx_next;
        end
    end

endmodule

@@ rtl/json_string_unescape_unit.sv @@
// Unescapes a JSON string given as UTF-16 code units, one unit per input beat,
// with s_tlast on the final unit of each string. Each output beat carries one
// unescaped unit, and m_tlast marks the last output beat caused by one input
// beat. An input beat is taken every cycle while the result queue has room; an
// input beat that gives no result (a backslash, the u of a unicode escape or a
// hex digit being collected) is taken but puts nothing on the output. Each
// result is one output beat, so an input beat that gives N results gives N
// output beats, at most three when a string ends inside a unicode escape. A
// queue of FIFO_DEPTH result groups sits between the decoder and the output
// serializer; with the default of two and m_tready held high, a stream with
// one result per input runs at one beat per cycle in both directions.
module json_string_unescape_unit import jsu_pkg::*; #(
    parameter int unsigned FIFO_DEPTH = JSU_FIFO_DEPTH
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [JSU_CHAR_W-1:0] s_tdata,   // [15:0] in_char
    input  logic                  s_tlast,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [JSU_CHAR_W-1:0] m_tdata,   // [15:0] out_char
    output logic                  m_tlast
);

    logic        push;
    jsu_bundle_t push_data;
    logic        pop;
    logic        head_valid;
    jsu_bundle_t head_data;

    jsu_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_char   (s_tdata),
        .in_last   (s_tlast),
        .push      (push),
        .push_data (push_data)
    );

    jsu_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_data  (push_data),
        .not_full   (s_tready),
        .pop        (pop),
        .head_valid (head_valid),
        .head_data  (head_data)
    );

    jsu_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head_data  (head_data),
        .pop        (pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_char   (m_tdata),
        .out_last   (m_tlast)
    );

endmodule

@@ rtl/jsu_checker.sv @@
module jsu_checker import jsu_pkg::*; (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic [JSU_CHAR_W-1:0] s_tdata,
    input logic                  s_tlast,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [JSU_CHAR_W-1:0] m_tdata,
    input logic                  m_tlast
);

    logic [1:0] run_reg, run_next;
    logic       m_beat;

    assign m_beat = m_tvalid && m_tready;

    always_comb begin
        run_next = run_reg;
        if (m_beat) begin
            run_next = m_tlast ? 2'd0 : run_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg <= 2'd0;
        end else begin
            run_next_check: assert (run_next <= 2'd2 || !m_beat || m_tlast)
                else $error("more than three beats in one result group");
            run_reg <= run_next;
        end
    end

    a_empty_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result beat offered right after reset");

    a_ready_after_reset: assert property (@(posedge aclk)
        !aresetn |=> s_tready)
        else $error("input not ready right after reset");

    a_group_length: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_beat && !m_tlast) |-> (run_reg < 2'd2))
        else $error("result group longer than three beats");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=>
            (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
        else $error("stalled result beat changed");

    a_input_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && !s_tready) |=>
            (s_tvalid && $stable(s_tdata) && $stable(s_tlast)))
        else $error("stalled input beat changed");

endmodule

bind json_string_unescape_unit jsu_checker u_jsu_checker (.*);
